>>> sv/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> sv/bmhq_pkg.sv
// Types and constants of the binary min-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int PRIO_W  = 16;
    localparam int PAY_W   = 32;
    localparam int ENTRY_W = PRIO_W + PAY_W;
    localparam int OCC_W   = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int STAT_W  = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PAY_W-1:0]  pay;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Compare request: moving entry against one or two neighbor entries.
    typedef struct packed {
        logic [PRIO_W-1:0] cand;
        logic [PRIO_W-1:0] left;
        logic [PRIO_W-1:0] right;
        logic              right_ok;
    } t_cmp_req;

    typedef struct packed {
        logic sel_right;
        logic chosen_lt_cand;
        logic cand_lt_chosen;
    } t_cmp_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_RM_LD,
        S_DN_CHK,
        S_DN_CMP,
        S_OUT
    } t_state;

endpackage

>>> sv/bmhq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/bmhq_cmp.sv
// Shared priority comparator: picks the smaller neighbor and ranks it against the moving entry.
`timescale 1ns / 1ps

module bmhq_cmp (
    input  bmhq_pkg::t_cmp_req i_req,
    output bmhq_pkg::t_cmp_res o_res
);

    logic [bmhq_pkg::PRIO_W-1:0] w_chosen;

    always_comb begin
        // Ties between the children go to the right one.
        o_res.sel_right      = i_req.right_ok && !(i_req.left < i_req.right);
        w_chosen             = o_res.sel_right ? i_req.right : i_req.left;
        o_res.chosen_lt_cand = w_chosen < i_req.cand;
        o_res.cand_lt_chosen = i_req.cand < w_chosen;
    end

endmodule

>>> sv/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap priority queue: sequencer, heap RAM and result register.
//
//  channel   | dir | fields (tuser / tdata, low bit first)
//  s_axis    | in  | tuser: opcode | tdata: priority_in, payload_in
//  m_axis    | out | tuser: status | tdata: priority_out, payload_out, occupancy, is_empty
//
// Insert starts at the end slot and climbs level by level until it reaches the root
// or a parent compare stops it; remove takes the root, moves the last entry there and sinks
// it level by level until it reaches a leaf or a child compare stops it.
// Each level is one registered RAM read and one pass through the shared comparator.
// Refused words skip the heap; tready is high only in idle; a waiting result holds the end.
// Synchronous active-low reset empties the heap; RAM contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_min_heap_queue_unit #(
    parameter int HEAP_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] priority_in, [47:16] payload_in
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] priority_out, [47:16] payload_out,
                                        // [56:48] occupancy, [57] is_empty, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    bmhq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    bmhq_pkg::t_entry  r_ent, n_ent;
    bmhq_pkg::t_entry  r_res, n_res;
    bmhq_pkg::t_status r_stat, n_stat;
    logic              r_rok, n_rok;
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_out_data, n_out_data;
    logic [1:0]        r_out_user, n_out_user;

    logic                         w_we;
    logic [AW-1:0]                w_waddr, w_raddr_a, w_raddr_b;
    logic [bmhq_pkg::ENTRY_W-1:0] w_wdata, w_rdata_a, w_rdata_b;
    bmhq_pkg::t_entry             w_rd_a, w_rd_b, w_in_ent;
    bmhq_pkg::t_cmp_req           w_req;
    bmhq_pkg::t_cmp_res           w_res;
    logic [XW-1:0]                w_lc, w_rc, w_cnt_x;
    logic [CW+bmhq_pkg::OCC_W-1:0] w_occ_x;
    logic                         w_accept;

    bmhq_ram #(
        .WIDTH(bmhq_pkg::ENTRY_W),
        .DEPTH(HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    bmhq_cmp u_cmp (
        .i_req (w_req),
        .o_res (w_res)
    );

    assign w_rd_a        = bmhq_pkg::t_entry'(w_rdata_a);
    assign w_rd_b        = bmhq_pkg::t_entry'(w_rdata_b);
    assign w_in_ent.prio = s_axis_tdata[15:0];
    assign w_in_ent.pay  = s_axis_tdata[47:16];
    assign w_lc          = {1'b0, r_pos, 1'b1};
    assign w_rc          = w_lc + XW'(1);
    assign w_cnt_x       = XW'(r_count);
    assign w_occ_x       = (CW + bmhq_pkg::OCC_W)'(r_count);
    assign s_axis_tready = (r_state == bmhq_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_ent      <= n_ent;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_rok      <= n_rok;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ent       = r_ent;
        n_res       = r_res;
        n_stat      = r_stat;
        n_rok       = r_rok;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_ent;
        w_raddr_a   = w_lc[AW-1:0];
        w_raddr_b   = w_rc[AW-1:0];
        w_req.cand     = r_ent.prio;
        w_req.left     = w_rd_a.prio;
        w_req.right    = w_rd_b.prio;
        w_req.right_ok = 1'b0;

        unique case (r_state)
            bmhq_pkg::S_IDLE: begin
                // Read root and last slot up front for a remove.
                w_raddr_a = '0;
                w_raddr_b = AW'(r_count - CW'(1));
                if (w_accept) begin
                    n_ent  = w_in_ent;
                    n_res  = '0;
                    n_stat = bmhq_pkg::ST_DONE;
                    if (bmhq_pkg::t_opcode'(s_axis_tuser[0]) == bmhq_pkg::OP_INSERT) begin
                        if (r_count == CW'(HEAP_DEPTH)) begin
                            n_stat  = bmhq_pkg::ST_FULL;
                            n_state = bmhq_pkg::S_OUT;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_state = bmhq_pkg::S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_stat  = bmhq_pkg::ST_EMPTY;
                            n_state = bmhq_pkg::S_OUT;
                        end else begin
                            n_state = bmhq_pkg::S_RM_LD;
                        end
                    end
                end
            end
            bmhq_pkg::S_UP_CHK: begin
                w_raddr_a = AW'((r_pos - AW'(1)) >> 1);
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = bmhq_pkg::S_OUT;
                end else begin
                    n_state = bmhq_pkg::S_UP_CMP;
                end
            end
            bmhq_pkg::S_UP_CMP: begin
                w_we = 1'b1;
                if (w_res.cand_lt_chosen) begin
                    // Move the parent down into the hole and climb.
                    w_wdata = w_rd_a;
                    n_pos   = AW'((r_pos - AW'(1)) >> 1);
                    n_state = bmhq_pkg::S_UP_CHK;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = bmhq_pkg::S_OUT;
                end
            end
            bmhq_pkg::S_RM_LD: begin
                n_res   = w_rd_a;
                n_ent   = w_rd_b;
                n_count = r_count - CW'(1);
                n_pos   = '0;
                n_state = bmhq_pkg::S_DN_CHK;
            end
            bmhq_pkg::S_DN_CHK: begin
                n_rok = w_rc < w_cnt_x;
                if (w_lc >= w_cnt_x) begin
                    w_we    = 1'b1;
                    n_state = bmhq_pkg::S_OUT;
                end else begin
                    n_state = bmhq_pkg::S_DN_CMP;
                end
            end
            bmhq_pkg::S_DN_CMP: begin
                w_req.right_ok = r_rok;
                w_we           = 1'b1;
                if (w_res.chosen_lt_cand) begin
                    // Pull the smaller child up into the hole and descend.
                    w_wdata = w_res.sel_right ? w_rd_b : w_rd_a;
                    n_pos   = w_res.sel_right ? w_rc[AW-1:0] : w_lc[AW-1:0];
                    n_state = bmhq_pkg::S_DN_CHK;
                end else begin
                    n_state = bmhq_pkg::S_OUT;
                end
            end
            bmhq_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_stat;
                    n_out_data  = {6'd0, (r_count == '0), w_occ_x[bmhq_pkg::OCC_W-1:0],
                                   r_res.pay, r_res.prio};
                    n_state     = bmhq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(HEAP_DEPTH))
    `ASSERT_SAME(a_remove_nonempty, i_clk, i_rst_n, r_state == bmhq_pkg::S_RM_LD, r_count != '0)
    `ASSERT_SAME(a_write_states, i_clk, i_rst_n, w_we,
        r_state == bmhq_pkg::S_UP_CHK || r_state == bmhq_pkg::S_UP_CMP ||
        r_state == bmhq_pkg::S_DN_CHK || r_state == bmhq_pkg::S_DN_CMP)
    `ASSERT_NEXT(a_full_refused, i_clk, i_rst_n,
        w_accept && !s_axis_tuser[0] && r_count == CW'(HEAP_DEPTH),
        r_state == bmhq_pkg::S_OUT && r_stat == bmhq_pkg::ST_FULL)

endmodule
